// File: rtl/core/ubts_pkg.sv
// ----------------------------------------------------------------------------
// ubts_pkg
// shared types and constants of the utf-8 bracket token scanner
// ----------------------------------------------------------------------------
package ubts_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CpW-1:0] OpenReset  = CpW'(32'h2329);
  localparam logic [CpW-1:0] CloseReset = CpW'(32'h232A);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOpen  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegClose = 1'b1;

  // lead byte prefixes
  localparam logic [4:0] Lead4 = 5'b11110;
  localparam logic [3:0] Lead3 = 4'b1110;
  localparam logic [2:0] Lead2 = 3'b110;
  localparam logic [1:0] Cont  = 2'b10;

  typedef enum logic [2:0] {
    KIND_LEFT  = 3'd0,
    KIND_RIGHT = 3'd1,
    KIND_CHAR  = 3'd2,
    KIND_END   = 3'd3,
    KIND_BAD   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    EV_POINT = 2'd0,
    EV_END   = 2'd1,
    EV_BAD   = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e       kind;
    logic [CpW-1:0] cp;
  } ev_t;

  typedef struct packed {
    kind_e          kind;
    logic [CpW-1:0] cp;
    logic           in_macro;
  } tok_t;

endpackage

// File: rtl/core/ubts_front.sv
// ----------------------------------------------------------------------------
// ubts_front
// utf-8 decoder: gathers bytes into code points and emits decode events
// ----------------------------------------------------------------------------
module ubts_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [ubts_pkg::ByteW-1:0] byte_in_i,
  input  logic                       end_of_input_i,
  output logic                       ev_push_o,
  output ubts_pkg::ev_t              ev_o
);
  import ubts_pkg::*;

  logic [1:0]     bytes_left_q, bytes_left_d;
  logic [CpW-1:0] partial_q, partial_d;
  logic [CpW-1:0] shifted;

  assign shifted = {partial_q[CpW-7:0], byte_in_i[5:0]};

  always_comb begin
    bytes_left_d = bytes_left_q;
    partial_d    = partial_q;
    ev_push_o    = 1'b0;
    ev_o.kind    = EV_POINT;
    ev_o.cp      = '0;
    if (accept_i) begin
      if (end_of_input_i) begin
        bytes_left_d = '0;
        partial_d    = '0;
        ev_push_o    = 1'b1;
        ev_o.kind    = EV_END;
      end else if (bytes_left_q != 2'd0) begin
        if (byte_in_i[7:6] != Cont) begin
          // broken sequence, byte consumed
          bytes_left_d = '0;
          partial_d    = '0;
          ev_push_o    = 1'b1;
          ev_o.kind    = EV_BAD;
        end else if (bytes_left_q == 2'd1) begin
          bytes_left_d = '0;
          partial_d    = '0;
          ev_push_o    = 1'b1;
          ev_o.cp      = shifted;
        end else begin
          bytes_left_d = bytes_left_q - 2'd1;
          partial_d    = shifted;
        end
      end else if (byte_in_i[7:3] == Lead4) begin
        partial_d    = CpW'(byte_in_i[2:0]);
        bytes_left_d = 2'd3;
      end else if (byte_in_i[7:4] == Lead3) begin
        partial_d    = CpW'(byte_in_i[3:0]);
        bytes_left_d = 2'd2;
      end else if (byte_in_i[7:5] == Lead2) begin
        partial_d    = CpW'(byte_in_i[4:0]);
        bytes_left_d = 2'd1;
      end else if (!byte_in_i[7]) begin
        ev_push_o = 1'b1;
        ev_o.cp   = CpW'(byte_in_i);
      end else begin
        // stray continuation byte or invalid lead byte
        partial_d = '0;
        ev_push_o = 1'b1;
        ev_o.kind = EV_BAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      partial_q    <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      partial_q    <= partial_d;
    end
  end

endmodule

// File: rtl/core/ubts_evq.sv
// ----------------------------------------------------------------------------
// ubts_evq
// short event queue between decoder and token stage
// ----------------------------------------------------------------------------
module ubts_evq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ubts_pkg::ev_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ubts_pkg::ev_t data_o
);
  import ubts_pkg::*;

  ev_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/ubts_back.sv
// ----------------------------------------------------------------------------
// ubts_back
// token stage: bracket matching, macro flag and the result queue
// ----------------------------------------------------------------------------
module ubts_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ev_empty_i,
  input  ubts_pkg::ev_t            ev_i,
  output logic                     ev_pop_o,
  input  logic [ubts_pkg::CpW-1:0] open_code_i,
  input  logic [ubts_pkg::CpW-1:0] close_code_i,
  input  logic                     pop_i,
  output logic                     empty_o,
  output ubts_pkg::tok_t           tok_o
);
  import ubts_pkg::*;

  logic             macro_q, macro_d;
  logic             tok_valid;
  tok_t             tok;
  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             oq_full, do_push, do_pop;

  assign oq_full  = (cnt_q == QCntW'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign ev_pop_o = !ev_empty_i && !oq_full;
  assign do_pop   = pop_i && !empty_o;
  assign do_push  = ev_pop_o && tok_valid;
  assign tok_o    = mem_q[rd_ptr_q];

  always_comb begin
    macro_d   = macro_q;
    tok_valid = 1'b0;
    tok.kind  = KIND_BAD;
    tok.cp    = '0;
    if (ev_pop_o) begin
      unique case (ev_i.kind)
        EV_END: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_END;
        end
        EV_BAD: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_BAD;
        end
        EV_POINT: begin
          tok.cp = ev_i.cp;
          // open test wins when both codes match
          if (ev_i.cp == open_code_i) begin
            macro_d   = 1'b1;
            tok_valid = 1'b1;
            tok.kind  = KIND_LEFT;
          end else if (ev_i.cp == close_code_i) begin
            macro_d   = 1'b0;
            tok_valid = 1'b1;
            tok.kind  = KIND_RIGHT;
          end else if (macro_q) begin
            tok_valid = 1'b1;
            tok.kind  = KIND_CHAR;
          end
        end
        default: begin
          tok_valid = 1'b0;
        end
      endcase
    end
    tok.in_macro = macro_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      macro_q  <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      macro_q <= macro_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/utf8_bracket_token_scanner.sv
// ----------------------------------------------------------------------------
// utf8_bracket_token_scanner
// decodes a utf-8 byte stream and hands out bracket, character, end and
// malformed tokens, tracking whether the stream is inside a bracketed macro
// ----------------------------------------------------------------------------
// path: a byte's event is written into the event queue, and the token stage
//   then writes its token into the result queue that drives the result ports
// throughput: one byte per cycle while full is low, set by the decoder update
//   and the one-event-per-cycle token stage; full only rises on result back-pressure
// reset: asynchronous, clears decoder state, macro flag and both queues, and
//   loads the default open and close codes
module utf8_bracket_token_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input
  input  logic                         push,
  output logic                         full,
  input  logic [ubts_pkg::ByteW-1:0]   byte_in_i,
  input  logic                         end_of_input_i,
  // token output
  output logic                         empty,
  input  logic                         pop,
  output logic [2:0]                   token_kind_o,
  output logic [ubts_pkg::CpW-1:0]     code_point_o,
  output logic                         in_macro_o,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [ubts_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ubts_pkg::CpW-1:0]     cfg_wdata_i
);
  import ubts_pkg::*;

  // configuration registers
  logic [CpW-1:0] open_code_q, close_code_q;

  // front to back event path
  logic accept;
  logic ev_push, ev_full, ev_empty, ev_pop;
  ev_t  ev_in, ev_out;
  tok_t tok;

  // an item is taken whenever the event queue has room
  assign full   = ev_full;
  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_code_q  <= OpenReset;
      close_code_q <= CloseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOpen:  open_code_q  <= cfg_wdata_i;
        RegClose: close_code_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // decoder: bytes in, code point / end / malformed events out
  ubts_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .byte_in_i,
    .end_of_input_i,
    .ev_push_o      (ev_push),
    .ev_o           (ev_in)
  );

  // decouples the decoder from result back-pressure
  ubts_evq u_evq (
    .clk_i,
    .rst_ni,
    .push_i  (ev_push),
    .data_i  (ev_in),
    .full_o  (ev_full),
    .pop_i   (ev_pop),
    .empty_o (ev_empty),
    .data_o  (ev_out)
  );

  // bracket matching, macro flag, result queue
  ubts_back u_back (
    .clk_i,
    .rst_ni,
    .ev_empty_i   (ev_empty),
    .ev_i         (ev_out),
    .ev_pop_o     (ev_pop),
    .open_code_i  (open_code_q),
    .close_code_i (close_code_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .tok_o        (tok)
  );

  assign token_kind_o = tok.kind;
  assign code_point_o = tok.cp;
  assign in_macro_o   = tok.in_macro;

  // the decoder never pushes an event that the queue cannot hold
  assert property (@(posedge clk_i) disable iff (!rst_ni) ev_push |-> !ev_full)
    else $error("event pushed into a full queue");

  // an end-of-input item always leaves an event behind for the token stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !full && end_of_input_i) |=> !ev_empty)
    else $error("end of input lost");

  // a left bracket always enters a macro, a right bracket always leaves one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && (token_kind_o == KIND_LEFT)) |-> in_macro_o)
    else $error("left bracket outside macro");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && (token_kind_o == KIND_RIGHT)) |-> !in_macro_o)
    else $error("right bracket inside macro");

  // end and malformed tokens carry no code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && ((token_kind_o == KIND_END) || (token_kind_o == KIND_BAD)))
                   |-> (code_point_o == '0))
    else $error("code point on end or malformed token");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 bracket token scanner: a queue-fed driver
// and a monitor, a token predictor kept beside the block, directed byte
// sequences and then random well-formed and broken utf-8 under several code
// settings and idling patterns
// ----------------------------------------------------------------------------
module tb_top;
  import ubts_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             eoi;
  } byte_item_t;

  // block ports, inputs all known from time zero
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             push           = 1'b0;
  logic             full;
  logic [ByteW-1:0] byte_in_i      = '0;
  logic             end_of_input_i = 1'b0;
  logic             empty;
  logic             pop            = 1'b0;
  logic [2:0]       token_kind_o;
  logic [CpW-1:0]   code_point_o;
  logic             in_macro_o;
  logic             cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [CpW-1:0]   cfg_wdata_i    = '0;

  // bytes waiting to be offered and tokens waiting to come out
  byte_item_t bytes_pending[$];
  tok_t       tokens_due[$];

  // predictor copy of the decoder state and the code registers
  logic [1:0]     dec_left  = '0;
  logic [CpW-1:0] dec_acc   = '0;
  logic           dec_macro = 1'b0;
  logic [CpW-1:0] cfg_open  = OpenReset;
  logic [CpW-1:0] cfg_close = CloseReset;

  // idling controls, set by the sequencing block at falling edges; hold counters kept by the monitor; error count
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned errors         = 0;

  // driver scratch
  tok_t drv_tok;
  bit   drv_go;
  tok_t mon_want;

  utf8_bracket_token_scanner DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .byte_in_i      (byte_in_i),
    .end_of_input_i (end_of_input_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .code_point_o   (code_point_o),
    .in_macro_o     (in_macro_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // a finished code point becomes a bracket, a character or nothing
  function automatic bit settle_point(input logic [CpW-1:0] pt, output tok_t tok);
    tok = '0;
    tok.cp = pt;
    // open test first, so equal codes always open
    if (pt == cfg_open) begin
      dec_macro = 1'b1;
      tok.kind = KIND_LEFT;
    end else if (pt == cfg_close) begin
      dec_macro = 1'b0;
      tok.kind = KIND_RIGHT;
    end else if (dec_macro) begin
      tok.kind = KIND_CHAR;
    end else begin
      return 1'b0;
    end
    tok.in_macro = dec_macro;
    return 1'b1;
  endfunction

  // token predictor: one byte in, zero or one token out
  function automatic bit scan_byte(input logic [ByteW-1:0] b, input logic eoi,
                                   output tok_t tok);
    logic [CpW-1:0] pt;
    tok = '0;
    tok.in_macro = dec_macro;
    if (eoi) begin
      // end drops any partial sequence but keeps the macro flag
      dec_left = '0;
      dec_acc  = '0;
      tok.kind = KIND_END;
      return 1'b1;
    end
    if (dec_left != 0) begin
      if (b[7:6] != Cont) begin
        // broken continuation: byte is eaten, sequence dropped
        dec_left = '0;
        dec_acc  = '0;
        tok.kind = KIND_BAD;
        return 1'b1;
      end
      dec_acc  = {dec_acc[CpW-7:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left != 0) return 1'b0;
      pt      = dec_acc;
      dec_acc = '0;
      return settle_point(pt, tok);
    end
    // lead byte, longest class first
    if (b[7:3] == Lead4) begin
      dec_acc  = CpW'(b[2:0]);
      dec_left = 2'd3;
      return 1'b0;
    end
    if (b[7:4] == Lead3) begin
      dec_acc  = CpW'(b[3:0]);
      dec_left = 2'd2;
      return 1'b0;
    end
    if (b[7:5] == Lead2) begin
      dec_acc  = CpW'(b[4:0]);
      dec_left = 2'd1;
      return 1'b0;
    end
    if (!b[7]) return settle_point(CpW'(b), tok);
    // stray continuation or 0xf8 and above
    dec_acc  = '0;
    tok.kind = KIND_BAD;
    return 1'b1;
  endfunction

  // driver: offers the head of the pending queue, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push           <= 1'b0;
      byte_in_i      <= '0;
      end_of_input_i <= 1'b0;
    end else begin
      if (push && !full) begin
        if (scan_byte(byte_in_i, end_of_input_i, drv_tok)) tokens_due.push_back(drv_tok);
        void'(bytes_pending.pop_front());
      end
      // an item refused by a full block is simply held
      if (!(push && full)) begin
        drv_go = (bytes_pending.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        push <= drv_go;
        if (drv_go) begin
          byte_in_i      <= bytes_pending[0].b;
          end_of_input_i <= bytes_pending[0].eoi;
        end
      end
    end
  end

  // monitor: checks each popped token against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (tokens_due.size() == 0) begin
          $error("token with no prediction waiting: kind %0d, code point %0h",
                 token_kind_o, code_point_o);
          errors++;
        end else begin
          mon_want = tokens_due.pop_front();
          if (token_kind_o !== mon_want.kind) begin
            $error("token_kind: expected %0d, got %0d", mon_want.kind, token_kind_o);
            errors++;
          end
          if (code_point_o !== mon_want.cp) begin
            $error("code_point: expected %0h, got %0h", mon_want.cp, code_point_o);
            errors++;
          end
          if (in_macro_o !== mon_want.in_macro) begin
            $error("in_macro: expected %0d, got %0d", mon_want.in_macro, in_macro_o);
            errors++;
          end
        end
      end
      // long hold-off on request, counted here so the sender keeps pushing
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic add_byte(input logic [ByteW-1:0] b);
    bytes_pending.push_back('{b: b, eoi: 1'b0});
  endtask

  // end item, with a random byte that the block must ignore
  task automatic add_end();
    bytes_pending.push_back('{b: ByteW'($urandom_range(255)), eoi: 1'b1});
  endtask

  // encodes a code point in len bytes; len 0 picks any legal length,
  // overlong ones included
  task automatic add_point(input logic [CpW-1:0] pt, input int len);
    int n;
    int lo;
    lo = (pt < 'h80) ? 1 : (pt < 'h800) ? 2 : (pt < 'h10000) ? 3 : 4;
    n  = (len == 0) ? $urandom_range(4, lo) : len;
    case (n)
      1: add_byte({1'b0, pt[6:0]});
      2: begin
        add_byte({Lead2, pt[10:6]});
        add_byte({Cont, pt[5:0]});
      end
      3: begin
        add_byte({Lead3, pt[15:12]});
        add_byte({Cont, pt[11:6]});
        add_byte({Cont, pt[5:0]});
      end
      default: begin
        add_byte({Lead4, pt[20:18]});
        add_byte({Cont, pt[17:12]});
        add_byte({Cont, pt[11:6]});
        add_byte({Cont, pt[5:0]});
      end
    endcase
  endtask

  // random stream: mostly whole sequences, some noise and broken ones
  task automatic add_random(input int count);
    int start;
    int r;
    int n;
    int k;
    logic [ByteW-1:0] b;
    start = bytes_pending.size();
    while (bytes_pending.size() - start < count) begin
      r = $urandom_range(99);
      if (r < 15) begin
        add_point(cfg_open, 0);
      end else if (r < 27) begin
        add_point(cfg_close, 0);
      end else if (r < 62) begin
        n = $urandom_range(4, 1);
        k = (n == 1) ? 7 : (n == 2) ? 11 : (n == 3) ? 16 : 21;
        add_point(CpW'($urandom & ((32'd1 << k) - 1)), n);
      end else if (r < 67) begin
        add_end();
      end else if (r < 77) begin
        add_byte(ByteW'($urandom_range(255)));
      end else if (r < 90) begin
        // sequence cut short by a non-continuation byte or by end of input
        n = $urandom_range(4, 2);
        add_byte((n == 2) ? {Lead2, 5'($urandom)} :
                 (n == 3) ? {Lead3, 4'($urandom)} : {Lead4, 3'($urandom)});
        k = $urandom_range(n - 2, 0);
        repeat (k) add_byte({Cont, 6'($urandom)});
        if ($urandom_range(3) == 0) begin
          add_end();
        end else begin
          do b = ByteW'($urandom_range(255)); while (b[7:6] == Cont);
          add_byte(b);
        end
      end else begin
        add_byte($urandom_range(1) ? {Cont, 6'($urandom)} : {5'b11111, 3'($urandom)});
      end
    end
  endtask

  // register write, only while the block is idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CpW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegOpen) cfg_open = val;
    else cfg_close = val;
  endtask

  // sender pause: everything offered, every token back, pipeline settled
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((bytes_pending.size() != 0 || tokens_due.size() != 0 || push) && guard < 50000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  // sequencing: reset, directed bytes, then random phases
  initial begin
    logic [CpW-1:0] open_v;
    logic [CpW-1:0] close_v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part under the reset codes
    add_byte(8'h00);               // ascii outside a macro, dropped
    add_point(CpW'(32'h2329), 3);  // open bracket
    add_byte(8'h7f);               // largest one-byte point
    add_byte(8'h00);               // smallest point as a character
    add_point(CpW'(32'h7ff), 2);   // largest two-byte point
    add_point(CpW'(32'h1fffff), 4);// largest four-byte value, not range-checked
    add_point(CpW'(0), 2);         // overlong zero
    add_byte(8'h80);               // stray continuation as a lead
    add_byte(8'hff);               // invalid lead
    add_byte(8'hf8);               // five-byte lead, invalid
    add_byte(8'he2);               // broken continuation
    add_byte(8'h41);
    add_point(CpW'(32'h232a), 3);  // close bracket
    add_byte(8'hf0);               // end in the middle of a sequence
    add_byte(8'h90);
    add_end();
    add_byte(8'h41);               // ascii outside a macro again
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin open_v = '0;               close_v = '1;              end
        1: begin open_v = '1;               close_v = '0;              end
        2: begin open_v = CpW'($urandom);   close_v = open_v;          end
        3: begin open_v = CpW'(32'h41);     close_v = CpW'(32'h42);    end
        4: begin open_v = CpW'($urandom);   close_v = CpW'($urandom);  end
        5: begin open_v = OpenReset;        close_v = CloseReset;      end
        6: begin open_v = CpW'($urandom_range(127)); close_v = CpW'($urandom_range(127)); end
        default: begin open_v = CpW'($urandom_range(2047)); close_v = CpW'($urandom); end
      endcase
      cfg_write(RegOpen, open_v);
      cfg_write(RegClose, close_v);
      @(negedge clk_i);
      // idling pattern cycles through none, sender, receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // long receiver hold-off while the sender pushes at full rate
      if (ph == 0 || ph == 4) hold_req++;
      add_random(128);
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (tokens_due.size() != 0) begin
      $error("%0d predicted tokens never came out", tokens_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
